// ===== src/fcull_pkg.sv =====
package fcull_pkg;

   // Plane register layout: three Q1.14 normal components, then the offset
   localparam int PLANE_BITS   = 64;
   localparam int COEF_BITS    = 16;
   localparam int FRAC_BITS    = 14;
   localparam int NUM_REGS     = 6;
   localparam int MAX_PLANES   = 8;
   localparam int CSR_IDX_BITS = 3;

   // Request and response field widths
   localparam int CMD_BITS     = 2;
   localparam int RADIUS_BITS  = 15;
   localparam int VERDICT_BITS = 2;

   // Defaults for the top-level parameters
   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int COORD_BITS_DEFAULT  = 16;

   // Test kinds
   localparam logic [CMD_BITS-1:0] CMD_POINT  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SPHERE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_BOX    = 2'd2;

   // Verdict codes
   localparam logic [VERDICT_BITS-1:0] VERDICT_OUTSIDE   = 2'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_INSIDE    = 2'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_INTERSECT = 2'd2;

   // Control that travels with a request from cell to cell
   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      logic                outside;
      logic                isect;
   } ctl_type;

endpackage

// ===== src/fcull_cell.sv =====
module fcull_cell #(
   parameter int COORD_BITS = fcull_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [fcull_pkg::PLANE_BITS-1:0]     plane,
   input  fcull_pkg::ctl_type                   ctl_i,
   input  logic [2:0][COORD_BITS-1:0]           a_i,
   input  logic [2:0][COORD_BITS-1:0]           b_i,
   input  logic [fcull_pkg::RADIUS_BITS-1:0]    rad_i,
   output fcull_pkg::ctl_type                   ctl_o,
   output logic [2:0][COORD_BITS-1:0]           a_o,
   output logic [2:0][COORD_BITS-1:0]           b_o,
   output logic [fcull_pkg::RADIUS_BITS-1:0]    rad_o
);

   localparam int PROD_BITS = fcull_pkg::COEF_BITS + COORD_BITS;
   localparam int OFS_BITS  = fcull_pkg::COEF_BITS + fcull_pkg::FRAC_BITS;
   localparam int DIST_BITS = ((PROD_BITS > OFS_BITS) ? PROD_BITS : OFS_BITS) + 2;

   logic signed [fcull_pkg::COEF_BITS-1:0] coef [3];
   logic signed [COORD_BITS-1:0]           pos_c [3];
   logic signed [COORD_BITS-1:0]           neg_c [3];
   logic signed [PROD_BITS-1:0]            prod_pos_in [3];
   logic signed [PROD_BITS-1:0]            prod_neg_in [3];

   fcull_pkg::ctl_type                     ctl_a_ff;
   logic [2:0][COORD_BITS-1:0]             a_a_ff;
   logic [2:0][COORD_BITS-1:0]             b_a_ff;
   logic [fcull_pkg::RADIUS_BITS-1:0]      rad_a_ff;
   logic signed [PROD_BITS-1:0]            prod_pos_ff [3];
   logic signed [PROD_BITS-1:0]            prod_neg_ff [3];

   logic signed [OFS_BITS-1:0]             ofs;
   logic signed [DIST_BITS-1:0]            dist_pos;
   logic signed [DIST_BITS-1:0]            dist_neg;
   logic signed [DIST_BITS-1:0]            rad_term;
   fcull_pkg::ctl_type                     ctl_b_in;

   fcull_pkg::ctl_type                     ctl_b_ff;
   logic [2:0][COORD_BITS-1:0]             a_b_ff;
   logic [2:0][COORD_BITS-1:0]             b_b_ff;
   logic [fcull_pkg::RADIUS_BITS-1:0]      rad_b_ff;

   // Pick box vertices by normal sign and form the per-axis products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef[k] = plane[k*fcull_pkg::COEF_BITS +: fcull_pkg::COEF_BITS];
         pos_c[k] = ((ctl_i.cmd == fcull_pkg::CMD_BOX) && (coef[k] > 0)) ? b_i[k] : a_i[k];
         neg_c[k] = (coef[k] < 0) ? b_i[k] : a_i[k];
         prod_pos_in[k] = coef[k] * pos_c[k];
         prod_neg_in[k] = coef[k] * neg_c[k];
      end
   end

   // Product stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
      end else begin
         ctl_a_ff <= ctl_i;
      end
      a_a_ff   <= a_i;
      b_a_ff   <= b_i;
      rad_a_ff <= rad_i;
      for (int k = 0; k < 3; k++) begin
         prod_pos_ff[k] <= prod_pos_in[k];
         prod_neg_ff[k] <= prod_neg_in[k];
      end
   end

   // Sum the products with the scaled offset
   assign ofs = {plane[3*fcull_pkg::COEF_BITS +: fcull_pkg::COEF_BITS],
                 {fcull_pkg::FRAC_BITS{1'b0}}};
   assign dist_pos = DIST_BITS'(prod_pos_ff[0]) + DIST_BITS'(prod_pos_ff[1])
                   + DIST_BITS'(prod_pos_ff[2]) + DIST_BITS'(ofs);
   assign dist_neg = DIST_BITS'(prod_neg_ff[0]) + DIST_BITS'(prod_neg_ff[1])
                   + DIST_BITS'(prod_neg_ff[2]) + DIST_BITS'(ofs);
   assign rad_term = DIST_BITS'({rad_a_ff, {fcull_pkg::FRAC_BITS{1'b0}}});

   // Fold this plane into the running flags
   always_comb begin
      ctl_b_in = ctl_a_ff;
      case (ctl_a_ff.cmd)
         fcull_pkg::CMD_POINT: begin
            ctl_b_in.outside = ctl_a_ff.outside | (dist_pos < 0);
         end
         fcull_pkg::CMD_SPHERE: begin
            ctl_b_in.outside = ctl_a_ff.outside | (dist_pos < -rad_term);
            ctl_b_in.isect   = ctl_a_ff.isect | (dist_pos < rad_term);
         end
         fcull_pkg::CMD_BOX: begin
            ctl_b_in.outside = ctl_a_ff.outside | (dist_pos < 0);
            ctl_b_in.isect   = ctl_a_ff.isect | (dist_neg < 0);
         end
         default: begin
            ctl_b_in.outside = 1'b1;
         end
      endcase
   end

   // Compare stage registers, handed to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
      end else begin
         ctl_b_ff <= ctl_b_in;
      end
      a_b_ff   <= a_a_ff;
      b_b_ff   <= b_a_ff;
      rad_b_ff <= rad_a_ff;
   end

   assign ctl_o = ctl_b_ff;
   assign a_o   = a_b_ff;
   assign b_o   = b_b_ff;
   assign rad_o = rad_b_ff;

endmodule

// ===== src/frustum_culling_test_core.sv =====
// Frustum culling test core.
// Software loads up to six plane registers through the csr_ port: csr_we high
// at a clock edge writes csr_wdata into the plane given by csr_index (top,
// bottom, left, right, near, far); other indexes are dropped. Planes must be
// written only while no request is in flight; the block does not enforce it.
// A request (point, sphere or axis-aligned box) is taken at each clock edge
// where start is high and busy is low. busy is low except during reset, so
// one request can be taken every cycle.
// Each plane has its own cell of two register stages (products, then sum and
// compare), and an output register follows the chain, so the verdict shows on
// rsp_verdict with rsp_valid high for one cycle, once the request has passed
// every cell and the output register. Verdicts leave in request order. The
// receiver cannot stall; it must take every result in the cycle it is shown.
// Reset (synchronous, active high) clears all plane registers to zero and
// drops every request in flight.
module frustum_culling_test_core #(
   parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEFAULT,
   parameter int COORD_BITS  = fcull_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [fcull_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic signed [COORD_BITS-1:0]          req_x_a,
   input  logic signed [COORD_BITS-1:0]          req_y_a,
   input  logic signed [COORD_BITS-1:0]          req_z_a,
   input  logic signed [COORD_BITS-1:0]          req_x_b,
   input  logic signed [COORD_BITS-1:0]          req_y_b,
   input  logic signed [COORD_BITS-1:0]          req_z_b,
   input  logic [fcull_pkg::RADIUS_BITS-1:0]     req_radius,
   output logic                                  rsp_valid,
   output logic [fcull_pkg::VERDICT_BITS-1:0]    rsp_verdict,
   input  logic                                  csr_we,
   input  logic [fcull_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [fcull_pkg::PLANE_BITS-1:0]      csr_wdata
);

   localparam int LATENCY = 2 * PLANE_COUNT + 1;

   logic [fcull_pkg::PLANE_BITS-1:0]   plane_ff [fcull_pkg::NUM_REGS];
   logic [fcull_pkg::PLANE_BITS-1:0]   plane_sel [PLANE_COUNT];

   fcull_pkg::ctl_type                 ctl_chain [PLANE_COUNT+1];
   logic [2:0][COORD_BITS-1:0]         a_chain [PLANE_COUNT+1];
   logic [2:0][COORD_BITS-1:0]         b_chain [PLANE_COUNT+1];
   logic [fcull_pkg::RADIUS_BITS-1:0]  rad_chain [PLANE_COUNT+1];

   logic                               rsp_valid_ff;
   logic [fcull_pkg::VERDICT_BITS-1:0] verdict_ff;
   logic [fcull_pkg::VERDICT_BITS-1:0] verdict_in;
   logic                               accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // Write plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < fcull_pkg::NUM_REGS; j++) begin
            plane_ff[j] <= '0;
         end
      end else if (csr_we) begin
         for (int j = 0; j < fcull_pkg::NUM_REGS; j++) begin
            if (csr_index == fcull_pkg::CSR_IDX_BITS'(j)) begin
               plane_ff[j] <= csr_wdata;
            end
         end
      end
   end

   // Planes past the register list have all-zero coefficients
   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
      if (i < fcull_pkg::NUM_REGS) begin : g_reg
         assign plane_sel[i] = plane_ff[i];
      end else begin : g_zero
         assign plane_sel[i] = '0;
      end
   end

   // Feed the request into the head of the chain
   always_comb begin
      ctl_chain[0].valid   = accept;
      ctl_chain[0].cmd     = req_cmd;
      ctl_chain[0].outside = 1'b0;
      ctl_chain[0].isect   = 1'b0;
      a_chain[0]   = {req_z_a, req_y_a, req_x_a};
      b_chain[0]   = {req_z_b, req_y_b, req_x_b};
      rad_chain[0] = req_radius;
   end

   // One cell per plane
   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
      fcull_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .plane (plane_sel[i]),
         .ctl_i (ctl_chain[i]),
         .a_i   (a_chain[i]),
         .b_i   (b_chain[i]),
         .rad_i (rad_chain[i]),
         .ctl_o (ctl_chain[i+1]),
         .a_o   (a_chain[i+1]),
         .b_o   (b_chain[i+1]),
         .rad_o (rad_chain[i+1])
      );
   end

   // Resolve the flags into a verdict
   always_comb begin
      if (ctl_chain[PLANE_COUNT].outside) begin
         verdict_in = fcull_pkg::VERDICT_OUTSIDE;
      end else if (ctl_chain[PLANE_COUNT].isect) begin
         verdict_in = fcull_pkg::VERDICT_INTERSECT;
      end else begin
         verdict_in = fcull_pkg::VERDICT_INSIDE;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_chain[PLANE_COUNT].valid;
      end
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

`ifndef SYNTH
   // Every taken request yields exactly one response after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request taken without a response at fixed latency");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   // A point test never answers intersecting
   a_point_verdict : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_cmd, LATENCY) == fcull_pkg::CMD_POINT))
      |-> (rsp_verdict != fcull_pkg::VERDICT_INTERSECT))
      else $error("point test answered intersecting");

   // The unused test kind always answers outside
   a_unused_cmd : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_cmd, LATENCY) != fcull_pkg::CMD_POINT)
       && ($past(req_cmd, LATENCY) != fcull_pkg::CMD_SPHERE)
       && ($past(req_cmd, LATENCY) != fcull_pkg::CMD_BOX))
      |-> (rsp_verdict == fcull_pkg::VERDICT_OUTSIDE))
      else $error("unused test kind not answered outside");
`endif

endmodule

// ===== verif/frustum_culling_test_core_tb.sv =====
`timescale 1ns / 1ps

module frustum_culling_test_core_tb;

   localparam int PLANES      = fcull_pkg::PLANE_COUNT_DEFAULT;
   localparam int COORD_W     = fcull_pkg::COORD_BITS_DEFAULT;
   localparam int LATENCY     = 2 * PLANES + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 50;
   localparam longint ONE_Q14 = 64'sd1 << fcull_pkg::FRAC_BITS;

   // Selector value with no test kind behind it
   localparam logic [fcull_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // Plane register indexes
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_TOP    = 3'd0;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_BOTTOM = 3'd1;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_LEFT   = 3'd2;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_RIGHT  = 3'd3;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_NEAR   = 3'd4;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_FAR    = 3'd5;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_SPARE0 = 3'd6;
   localparam logic [fcull_pkg::CSR_IDX_BITS-1:0] IDX_SPARE1 = 3'd7;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   start = 1'b0;
   logic                                   busy;
   logic [fcull_pkg::CMD_BITS-1:0]         req_cmd = fcull_pkg::CMD_POINT;
   logic signed [COORD_W-1:0]              req_x_a = '0;
   logic signed [COORD_W-1:0]              req_y_a = '0;
   logic signed [COORD_W-1:0]              req_z_a = '0;
   logic signed [COORD_W-1:0]              req_x_b = '0;
   logic signed [COORD_W-1:0]              req_y_b = '0;
   logic signed [COORD_W-1:0]              req_z_b = '0;
   logic [fcull_pkg::RADIUS_BITS-1:0]      req_radius = '0;
   logic                                   rsp_valid;
   logic [fcull_pkg::VERDICT_BITS-1:0]     rsp_verdict;
   logic                                   csr_we = 1'b0;
   logic [fcull_pkg::CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [fcull_pkg::PLANE_BITS-1:0]       csr_wdata = '0;

   // Shadow copy of the plane registers; entries past the list stay zero
   logic [fcull_pkg::PLANE_BITS-1:0]       plane_shadow [0:fcull_pkg::MAX_PLANES-1];
   logic [fcull_pkg::VERDICT_BITS-1:0]     expected_verdicts [$];
   logic [fcull_pkg::VERDICT_BITS-1:0]     verdict_head;
   int                                     error_count = 0;
   int                                     cycle_count = 0;
   int                                     burst_left = 0;

   frustum_culling_test_core #(
      .PLANE_COUNT(PLANES),
      .COORD_BITS (COORD_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_x_a    (req_x_a),
      .req_y_a    (req_y_a),
      .req_z_a    (req_z_a),
      .req_x_b    (req_x_b),
      .req_y_b    (req_y_b),
      .req_z_b    (req_z_b),
      .req_radius (req_radius),
      .rsp_valid  (rsp_valid),
      .rsp_verdict(rsp_verdict),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Signed distance of a point to one plane, in Q.14 coordinate units
   function automatic longint plane_distance(input logic [fcull_pkg::PLANE_BITS-1:0] pl,
                                             input longint x, input longint y,
                                             input longint z);
      longint nx, ny, nz, d;
      nx = $signed(pl[15:0]);
      ny = $signed(pl[31:16]);
      nz = $signed(pl[47:32]);
      d  = $signed(pl[63:48]);
      return nx * x + ny * y + nz * z + d * ONE_Q14;
   endfunction

   // Expected verdict for one request against the shadow planes
   function automatic logic [fcull_pkg::VERDICT_BITS-1:0] classify_object(
         input logic [fcull_pkg::CMD_BITS-1:0] cmd,
         input logic signed [COORD_W-1:0] xa, input logic signed [COORD_W-1:0] ya,
         input logic signed [COORD_W-1:0] za, input logic signed [COORD_W-1:0] xb,
         input logic signed [COORD_W-1:0] yb, input logic signed [COORD_W-1:0] zb,
         input logic [fcull_pkg::RADIUS_BITS-1:0] radius);
      longint ax, ay, az, bx, by, bz, r, dd, dn, nx, ny, nz;
      logic [fcull_pkg::PLANE_BITS-1:0] pl;
      logic [fcull_pkg::VERDICT_BITS-1:0] verdict;
      bit done;
      ax = xa; ay = ya; az = za;
      bx = xb; by = yb; bz = zb;
      r = longint'(radius) * ONE_Q14;
      verdict = fcull_pkg::VERDICT_INSIDE;
      done = 1'b0;
      if (cmd == CMD_UNUSED)
         return fcull_pkg::VERDICT_OUTSIDE;
      for (int i = 0; i < PLANES && i < fcull_pkg::MAX_PLANES; i++) begin
         if (!done) begin
            pl = plane_shadow[i];
            if (cmd == fcull_pkg::CMD_POINT) begin
               if (plane_distance(pl, ax, ay, az) < 0) begin
                  verdict = fcull_pkg::VERDICT_OUTSIDE;
                  done = 1'b1;
               end
            end else if (cmd == fcull_pkg::CMD_SPHERE) begin
               dd = plane_distance(pl, ax, ay, az);
               if (dd < -r) begin
                  verdict = fcull_pkg::VERDICT_OUTSIDE;
                  done = 1'b1;
               end else if (dd < r) begin
                  verdict = fcull_pkg::VERDICT_INTERSECT;
               end
            end else begin
               // Positive vertex decides outside, negative vertex decides straddle
               nx = $signed(pl[15:0]);
               ny = $signed(pl[31:16]);
               nz = $signed(pl[47:32]);
               dd = plane_distance(pl, nx > 0 ? bx : ax, ny > 0 ? by : ay,
                                   nz > 0 ? bz : az);
               dn = plane_distance(pl, nx < 0 ? bx : ax, ny < 0 ? by : ay,
                                   nz < 0 ? bz : az);
               if (dd < 0) begin
                  verdict = fcull_pkg::VERDICT_OUTSIDE;
                  done = 1'b1;
               end else if (dn < 0) begin
                  verdict = fcull_pkg::VERDICT_INTERSECT;
               end
            end
         end
      end
      return verdict;
   endfunction

   function automatic logic [fcull_pkg::PLANE_BITS-1:0] pack_plane(input int nx,
         input int ny, input int nz, input int d);
      return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      if ($urandom_range(0, 3) == 0)
         return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(0, 40000)) - 20000);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Send one request, with random bursts and gaps on the request side
   task automatic send_request(input logic [fcull_pkg::CMD_BITS-1:0] cmd,
         input logic signed [COORD_W-1:0] xa, input logic signed [COORD_W-1:0] ya,
         input logic signed [COORD_W-1:0] za, input logic signed [COORD_W-1:0] xb,
         input logic signed [COORD_W-1:0] yb, input logic signed [COORD_W-1:0] zb,
         input logic [fcull_pkg::RADIUS_BITS-1:0] radius);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_cmd    <= cmd;
      req_x_a    <= xa;
      req_y_a    <= ya;
      req_z_a    <= za;
      req_x_b    <= xb;
      req_y_b    <= yb;
      req_z_b    <= zb;
      req_radius <= radius;
      start      <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_verdicts.push_back(classify_object(cmd, xa, ya, za, xb, yb, zb, radius));
   endtask

   // Hold off requests until every verdict in flight has come back
   task automatic wait_for_verdicts();
      start <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_plane(input logic [fcull_pkg::CSR_IDX_BITS-1:0] idx,
                              input logic [fcull_pkg::PLANE_BITS-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we    <= 1'b1;
      @(posedge clock);
      if (idx < fcull_pkg::NUM_REGS)
         plane_shadow[idx] = data;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_planes(input logic [fcull_pkg::PLANE_BITS-1:0] data);
      for (int i = 0; i < fcull_pkg::NUM_REGS; i++)
         write_plane(fcull_pkg::CSR_IDX_BITS'(i), data);
   endtask

   // Planes are all zero after reset: every distance is zero
   task automatic test_reset_planes();
      send_request(fcull_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_SPHERE, 5, -5, 9, 0, 0, 0, 7);
      send_request(fcull_pkg::CMD_BOX, -4, -4, -4, 4, 4, 4, 0);
      send_request(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0);
      wait_for_verdicts();
   endtask

   // Axis-aligned frustum, boundaries, extremes, inverted box, unused selector
   task automatic test_axis_frustum();
      write_plane(IDX_TOP,    pack_plane(0, -16384, 0, 1000));
      write_plane(IDX_BOTTOM, pack_plane(0, 16384, 0, 1000));
      write_plane(IDX_LEFT,   pack_plane(16384, 0, 0, 1000));
      write_plane(IDX_RIGHT,  pack_plane(-16384, 0, 0, 1000));
      write_plane(IDX_NEAR,   pack_plane(0, 0, 16384, 1000));
      write_plane(IDX_FAR,    pack_plane(0, 0, -16384, 2000));
      send_request(fcull_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_POINT, -1000, 1000, 2000, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_POINT, -1001, 0, 0, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_POINT, 32767, 32767, 32767, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 10);
      send_request(fcull_pkg::CMD_SPHERE, 995, 0, 0, 0, 0, 0, 10);
      send_request(fcull_pkg::CMD_SPHERE, 1011, 0, 0, 0, 0, 0, 10);
      send_request(fcull_pkg::CMD_SPHERE, 0, 0, 0, -32768, 32767, -1, 15'h7FFF);
      send_request(fcull_pkg::CMD_BOX, -10, -10, -10, 10, 10, 10, 0);
      send_request(fcull_pkg::CMD_BOX, 900, 0, 0, 1100, 10, 10, 0);
      send_request(fcull_pkg::CMD_BOX, 1100, 0, 0, 1200, 10, 10, 0);
      send_request(fcull_pkg::CMD_BOX, 10, 10, 10, -10, -10, -10, 0);
      send_request(fcull_pkg::CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                   15'h7FFF);
      send_request(CMD_UNUSED, 1, 2, 3, 4, 5, 6, 15'h7FFF);
      wait_for_verdicts();
   endtask

   // Writes past the register list must be dropped
   task automatic test_ignored_index();
      write_plane(IDX_SPARE0, '1);
      write_plane(IDX_SPARE1, pack_plane(-16384, -16384, -16384, -32768));
      send_request(fcull_pkg::CMD_POINT, 3, 4, 5, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_SPHERE, 3, 4, 5, 0, 0, 0, 1);
      wait_for_verdicts();
   endtask

   // Coefficient extremes in every field
   task automatic test_coef_extremes();
      write_all_planes(64'h8000_8000_8000_8000);
      send_request(fcull_pkg::CMD_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
      send_request(fcull_pkg::CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0);
      wait_for_verdicts();
      write_all_planes(64'h7FFF_7FFF_7FFF_7FFF);
      send_request(fcull_pkg::CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 15'h7FFF);
      wait_for_verdicts();
      write_all_planes('1);
      send_request(fcull_pkg::CMD_POINT, -1, 0, 0, 0, 0, 0, 0);
      wait_for_verdicts();
   endtask

   // Random phases: reload the planes, then stream random objects
   task automatic test_random_phases();
      int n [3];
      int axis, mag;
      logic [fcull_pkg::PLANE_BITS-1:0] pl;
      logic [fcull_pkg::CMD_BITS-1:0] cmd;
      logic signed [COORD_W-1:0] xa, ya, za, xb, yb, zb;
      logic [fcull_pkg::RADIUS_BITS-1:0] radius;
      int pick;
      for (int phase = 0; phase < 6; phase++) begin
         // Mostly a jittered box frustum, some fully random planes
         for (int i = 0; i < fcull_pkg::NUM_REGS; i++) begin
            axis = (i < 2) ? 1 : (i < 4) ? 0 : 2;
            mag = $urandom_range(4096, 32767);
            for (int k = 0; k < 3; k++)
               n[k] = int'($urandom_range(0, 4000)) - 2000;
            n[axis] = (i == IDX_BOTTOM || i == IDX_LEFT || i == IDX_NEAR) ? mag : -mag;
            pl = pack_plane(n[0], n[1], n[2], $urandom_range(0, 16000));
            if (phase == 1 || $urandom_range(0, 7) == 0)
               pl = {$urandom, $urandom};
            write_plane(fcull_pkg::CSR_IDX_BITS'(i), pl);
         end
         for (int j = 0; j < 66; j++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 30) ? fcull_pkg::CMD_POINT : (pick < 60) ? fcull_pkg::CMD_SPHERE :
                  (pick < 95) ? fcull_pkg::CMD_BOX : CMD_UNUSED;
            xa = rand_coord();
            ya = rand_coord();
            za = rand_coord();
            if ($urandom_range(0, 4) == 0) begin
               xb = rand_coord();
               yb = rand_coord();
               zb = rand_coord();
            end else begin
               xb = xa + COORD_W'($urandom_range(0, 3000));
               yb = ya + COORD_W'($urandom_range(0, 3000));
               zb = za + COORD_W'($urandom_range(0, 3000));
            end
            radius = ($urandom_range(0, 9) < 7) ?
                     fcull_pkg::RADIUS_BITS'($urandom_range(0, 4000)) :
                     fcull_pkg::RADIUS_BITS'($urandom);
            send_request(cmd, xa, ya, za, xb, yb, zb, radius);
         end
         wait_for_verdicts();
      end
   endtask

   // Compare each verdict with the oldest pending request
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d with no request pending", rsp_verdict));
         end else begin
            verdict_head = expected_verdicts.pop_front();
            if (rsp_verdict !== verdict_head)
               report_mismatch($sformatf("verdict got %0d expected %0d",
                                         rsp_verdict, verdict_head));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("frustum_culling_test_core_tb failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < fcull_pkg::MAX_PLANES; i++)
         plane_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_planes();
      test_axis_frustum();
      test_ignored_index();
      test_coef_extremes();
      test_random_phases();
      wait_for_verdicts();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("frustum_culling_test_core_tb passed");
      end else begin
         $display("frustum_culling_test_core_tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/fcull_pkg.sv
src/fcull_cell.sv
src/frustum_culling_test_core.sv
verif/frustum_culling_test_core_tb.sv
